/* hdl/svpwm_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_pkg
// Shared types, codes and constants for the servo PWM generator.
// ---------------------------------------------------------------------------
package svpwm_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int CFG_WIDTH   = 16;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ANGLE = 2'd1,
        OP_PULSE = 2'd2
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_PRESCALE_DIV = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TOP   = 2'd1;

    localparam logic [CFG_WIDTH-1:0]   PRESCALE_RESET = 16'd15;
    localparam logic [CFG_WIDTH-1:0]   PERIOD_RESET   = 16'd19999;
    localparam logic [COUNT_WIDTH-1:0] COMPARE_RESET  = 16'd1500;

    localparam logic [VALUE_WIDTH-1:0] PULSE_MIN = 16'd1000;
    localparam logic [VALUE_WIDTH-1:0] PULSE_MAX = 16'd2000;
    localparam logic [7:0]             ANGLE_MAX = 8'd180;

    // angle*1000/180 == (angle*364100) >> 16 for angle in 0..180
    localparam int ANGLE_MUL_W = 27;
    localparam logic [18:0] ANGLE_RECIP = 19'd364100;
    localparam int ANGLE_SHIFT = 16;

    typedef struct packed {
        logic                   wr;
        logic [COUNT_WIDTH-1:0] data;
    } preload_wr_t;

endpackage

/* hdl/svpwm_cmd.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_cmd
// Decodes angle and pulse commands into a clamped preload compare value.
// ---------------------------------------------------------------------------
module svpwm_cmd
    import svpwm_pkg::*;
(
    input  op_t                    op,
    input  logic [VALUE_WIDTH-1:0] value,
    output preload_wr_t            preload
);

    logic [7:0]             angle;
    logic [ANGLE_MUL_W-1:0] angle_prod;
    logic [VALUE_WIDTH-1:0] angle_pulse;
    logic [VALUE_WIDTH-1:0] pulse_clamped;

    always_comb begin
        angle = (value > {8'd0, ANGLE_MAX}) ? ANGLE_MAX : value[7:0];
        angle_prod  = ANGLE_MUL_W'(angle) * ANGLE_MUL_W'(ANGLE_RECIP);
        angle_pulse = PULSE_MIN + VALUE_WIDTH'(angle_prod >> ANGLE_SHIFT);

        if (value < PULSE_MIN) begin
            pulse_clamped = PULSE_MIN;
        end else if (value > PULSE_MAX) begin
            pulse_clamped = PULSE_MAX;
        end else begin
            pulse_clamped = value;
        end
    end

    always_comb begin
        preload.wr   = 1'b0;
        preload.data = pulse_clamped;
        unique case (op)
            OP_ANGLE: begin
                preload.wr   = 1'b1;
                preload.data = angle_pulse;
            end
            OP_PULSE: begin
                preload.wr   = 1'b1;
                preload.data = pulse_clamped;
            end
            default: begin
                preload.wr = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/svpwm_timer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svpwm_timer
// Prescaler, period counter and preloaded compare; produces the output
// level, active compare and wrap flag for the state after each request.
// ---------------------------------------------------------------------------
module svpwm_timer
    import svpwm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  op_t                    op,
    input  preload_wr_t            preload,
    input  logic [CFG_WIDTH-1:0]   prescale_div,
    input  logic [CFG_WIDTH-1:0]   period_top,
    output logic                   pwm_level,
    output logic [COUNT_WIDTH-1:0] pulse_width,
    output logic                   period_wrap
);

    logic [CFG_WIDTH-1:0]   prescale_count_reg, prescale_count_next;
    logic [COUNT_WIDTH-1:0] period_count_reg, period_count_next;
    logic [COUNT_WIDTH-1:0] compare_active_reg, compare_active_next;
    logic [COUNT_WIDTH-1:0] compare_preload_reg, compare_preload_next;
    logic                   wrap;

    always_comb begin
        prescale_count_next  = prescale_count_reg;
        period_count_next    = period_count_reg;
        compare_active_next  = compare_active_reg;
        compare_preload_next = compare_preload_reg;
        wrap                 = 1'b0;

        if (op == OP_TICK) begin
            if (prescale_count_reg >= prescale_div) begin
                prescale_count_next = '0;
                if (period_count_reg >= period_top) begin
                    period_count_next   = '0;
                    compare_active_next = compare_preload_reg;
                    wrap                = 1'b1;
                end else begin
                    period_count_next = period_count_reg + 1'b1;
                end
            end else begin
                prescale_count_next = prescale_count_reg + 1'b1;
            end
        end

        if (preload.wr) begin
            compare_preload_next = preload.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_count_reg  <= '0;
            period_count_reg    <= '0;
            compare_active_reg  <= COMPARE_RESET;
            compare_preload_reg <= COMPARE_RESET;
        end else if (advance) begin
            prescale_count_reg  <= prescale_count_next;
            period_count_reg    <= period_count_next;
            compare_active_reg  <= compare_active_next;
            compare_preload_reg <= compare_preload_next;
        end
    end

    assign pwm_level   = (period_count_next < compare_active_next);
    assign pulse_width = compare_active_next;
    assign period_wrap = wrap;

endmodule

/* hdl/servo_pwm_generator.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// servo_pwm_generator
// RC servo PWM timer with prescaler, period counter and preloaded compare.
// ---------------------------------------------------------------------------
// Accepts one request per cycle while s_ready is high and returns exactly
// one result per request. A request is captured in an input register; the
// timer state update and the command decode (one 8x19 constant multiply for
// the angle map) sit between that register and the result register.
// s_ready stays high while the input register is empty or the result
// register is free or being taken. Configuration writes (prescale_div at
// index 0, period_top at index 1; other indexes are ignored) take effect on
// the next request and are meant to be issued while the block is idle.
module servo_pwm_generator
    import svpwm_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_operation,
    input  logic [VALUE_WIDTH-1:0] s_value,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_pwm_level,
    output logic [COUNT_WIDTH-1:0] m_pulse_width,
    output logic                   m_period_wrap
);

    logic [CFG_WIDTH-1:0]   prescale_div_reg;
    logic [CFG_WIDTH-1:0]   period_top_reg;

    logic                   in_valid_reg;
    op_t                    op_reg;
    logic [VALUE_WIDTH-1:0] value_reg;

    logic                   out_valid_reg;
    logic                   pwm_level_reg;
    logic [COUNT_WIDTH-1:0] pulse_width_reg;
    logic                   period_wrap_reg;

    logic                   advance;
    preload_wr_t            preload;
    logic                   pwm_level_next;
    logic [COUNT_WIDTH-1:0] pulse_width_next;
    logic                   period_wrap_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_div_reg <= PRESCALE_RESET;
            period_top_reg   <= PERIOD_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PRESCALE_DIV: prescale_div_reg <= cfg_data;
                REG_PERIOD_TOP:   period_top_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= op_t'(s_operation);
            value_reg <= s_value;
        end
    end

    svpwm_cmd u_cmd (
        .op      (op_reg),
        .value   (value_reg),
        .preload (preload)
    );

    svpwm_timer u_timer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .advance      (advance),
        .op           (op_reg),
        .preload      (preload),
        .prescale_div (prescale_div_reg),
        .period_top   (period_top_reg),
        .pwm_level    (pwm_level_next),
        .pulse_width  (pulse_width_next),
        .period_wrap  (period_wrap_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pwm_level_reg   <= pwm_level_next;
            pulse_width_reg <= pulse_width_next;
            period_wrap_reg <= period_wrap_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pwm_level   = pwm_level_reg;
    assign m_pulse_width = pulse_width_reg;
    assign m_period_wrap = period_wrap_reg;

endmodule
